// ----- design/ccl_pkg.sv -----
// Shared types and constants for the charge sharing frame cleanup block.
package ccl_pkg;

  localparam int FRAME_WIDTH  = 80;
  localparam int FRAME_HEIGHT = 80;
  localparam int STRIDE       = 20;

  localparam int PIX_W  = 16;
  localparam int SUM_W  = 21;
  localparam int HITS_W = 5;
  localparam int POS_W  = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_HIGH = 2'd1,
    REG_MODE = 2'd2,
    REG_WIN  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_REORDER = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_DISCR   = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    RS_IN  = 2'd0,
    RS_CTR = 2'd1,
    RS_WIN = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CTR,
    S_CHK,
    S_WIN_RD,
    S_WIN_ACC,
    S_DECIDE,
    S_CLR,
    S_PUT
  } state_t;

  typedef struct packed {
    logic    load_wr;
    rd_sel_t rd_sel;
    logic    ctr_clear;
    logic    ctr_next;
    logic    win_start;
    logic    win_acc;
    logic    win_next;
    logic    win_rewind;
    logic    clr_wr;
    logic    put_wr;
    logic    out_read;
    logic    out_zero;
    logic    out_done;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic load_ok;
    logic read_ok;
    logic run_on;
    logic add_mode;
    logic ctr_hit;
    logic ctr_last;
    logic win_last;
    logic shared;
    logic out_busy;
  } sts_t;

endpackage

// ----- design/charge_sharing_frame_cleanup.sv -----
// Top level of the charge sharing frame cleanup block.
// Input words on s_*: s_tuser is the operation (load, run, read), s_tdata carries
// raw value, row and column. Loads store a raw pixel, un-interleaving each row
// into image columns; they give no output word.
// A read returns one m_* word (m_tuser = 1, m_tdata = pixel); m_tvalid is set from
// S_READ, the state after the accepting edge, or at the accepting edge itself when the
// position is out of the frame.
// A run in add or discriminate mode scans the frame in raster order with a 3x3 or 5x5
// window and cleans shared-charge events in place; every run returns a word with m_tuser = 0.
// Run steps: a scanned pixel is read (S_CTR) and checked (S_CHK); a hit reads and
// sums each window pixel (S_WIN_RD, S_WIN_ACC) through the single memory read port;
// shared windows are cleared (S_DECIDE, S_CLR); add mode puts the sum at the peak (S_PUT).
// One word is in flight at a time: s_tready is low while a run or read is busy
// and while an output word waits, so a stalled receiver holds back the input.
// The user makes config writes (cfg_we, cfg_index, cfg_data) only while the block is
// idle; the block does not enforce it. Synchronous reset returns the controller to idle,
// drops m_tvalid and loads the register defaults; frame contents are undefined until loaded.
module charge_sharing_frame_cleanup #(
  parameter int WIDTH             = ccl_pkg::FRAME_WIDTH,
  parameter int HEIGHT            = ccl_pkg::FRAME_HEIGHT,
  parameter int INTERLEAVE_STRIDE = ccl_pkg::STRIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ccl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccl_pkg::PIX_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // raw_value[15:0], row[22:16], column[29:23]
  input  logic [1:0]                    s_tuser,   // operation[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // pixel_value[15:0]
  output logic                          m_tuser    // result_kind[0]
);
  import ccl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ccl_dp #(
    .WIDTH            (WIDTH),
    .HEIGHT           (HEIGHT),
    .INTERLEAVE_STRIDE(INTERLEAVE_STRIDE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !m_tvalid)
    else $error("input taken while an output word waits");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_LOAD) |=> s_tready)
    else $error("load did not return to idle");

endmodule

// ----- design/ccl_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module ccl_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 6400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ccl_ctrl.sv -----
// Controller state machine: sequences loads, reads and the frame cleanup scan.
module ccl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  ccl_pkg::sts_t sts,
  output ccl_pkg::cmd_t cmd
);
  import ccl_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.op == OP_READ && sts.read_ok) begin
            state_next = S_READ;
          end else if (sts.op == OP_RUN && sts.run_on) begin
            state_next = S_CTR;
          end
        end
      end
      S_READ: state_next = S_IDLE;
      S_CTR:  state_next = S_CHK;
      S_CHK: begin
        if (sts.ctr_hit) begin
          state_next = S_WIN_RD;
        end else begin
          state_next = sts.ctr_last ? S_IDLE : S_CTR;
        end
      end
      S_WIN_RD:  state_next = S_WIN_ACC;
      S_WIN_ACC: state_next = sts.win_last ? S_DECIDE : S_WIN_RD;
      S_DECIDE: begin
        if (sts.shared) begin
          state_next = S_CLR;
        end else begin
          state_next = sts.ctr_last ? S_IDLE : S_CTR;
        end
      end
      S_CLR: begin
        if (!sts.win_last) begin
          state_next = S_CLR;
        end else if (sts.add_mode) begin
          state_next = S_PUT;
        end else begin
          state_next = sts.ctr_last ? S_IDLE : S_CTR;
        end
      end
      S_PUT:   state_next = sts.ctr_last ? S_IDLE : S_CTR;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RS_IN;
    s_tready = (state == S_IDLE) && !sts.out_busy;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (sts.op)
            OP_LOAD: cmd.load_wr = sts.load_ok;
            OP_READ: cmd.out_zero = !sts.read_ok;
            OP_RUN: begin
              cmd.ctr_clear = sts.run_on;
              cmd.out_done  = !sts.run_on;
            end
            default: ;
          endcase
        end
      end
      S_READ: cmd.out_read = 1'b1;
      S_CTR:  cmd.rd_sel = RS_CTR;
      S_CHK: begin
        if (sts.ctr_hit) begin
          cmd.win_start = 1'b1;
        end else begin
          cmd.ctr_next = !sts.ctr_last;
          cmd.out_done = sts.ctr_last;
        end
      end
      S_WIN_RD: cmd.rd_sel = RS_WIN;
      S_WIN_ACC: begin
        cmd.win_acc  = 1'b1;
        cmd.win_next = !sts.win_last;
      end
      S_DECIDE: begin
        if (sts.shared) begin
          cmd.win_rewind = 1'b1;
        end else begin
          cmd.ctr_next = !sts.ctr_last;
          cmd.out_done = sts.ctr_last;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (!sts.win_last) begin
          cmd.win_next = 1'b1;
        end else if (!sts.add_mode) begin
          cmd.ctr_next = !sts.ctr_last;
          cmd.out_done = sts.ctr_last;
        end
      end
      S_PUT: begin
        cmd.put_wr   = 1'b1;
        cmd.ctr_next = !sts.ctr_last;
        cmd.out_done = sts.ctr_last;
      end
      default: ;
    endcase
  end

  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && sts.op == OP_RUN) |=> !s_tready)
    else $error("input accepted right after a run word");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_done |-> (state_next == S_IDLE))
    else $error("run finish reported while scan continues");

endmodule

// ----- design/ccl_dp.sv -----
// Datapath: config registers, frame store, scan pointers, window sums, output register.
module ccl_dp #(
  parameter int WIDTH             = ccl_pkg::FRAME_WIDTH,
  parameter int HEIGHT            = ccl_pkg::FRAME_HEIGHT,
  parameter int INTERLEAVE_STRIDE = ccl_pkg::STRIDE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ccl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccl_pkg::PIX_W-1:0]      cfg_data,
  input  logic [31:0]                    s_tdata,
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,
  output logic                           m_tuser,
  input  ccl_pkg::cmd_t                  cmd,
  output ccl_pkg::sts_t                  sts
);
  import ccl_pkg::*;

  localparam int YW = $clog2(HEIGHT);
  localparam int XW = $clog2(WIDTH);
  localparam int AW = $clog2(WIDTH * HEIGHT);
  localparam int CW = 9;

  logic [PIX_W-1:0] low_thr, high_thr;
  mode_t            mode;
  logic             win_sel;

  logic [PIX_W-1:0] raw_value;
  logic [POS_W-1:0] row, column;
  logic [CW-1:0]    load_col;
  logic [AW-1:0]    in_raddr, in_waddr;

  logic [YW-1:0] cy, wy, y0, y1, py, y0_new, y1_new;
  logic [XW-1:0] cx, wx, x0, x1, px, x0_new, x1_new;
  logic [YW:0]   cye, yhi, half_y;
  logic [XW:0]   cxe, xhi, half_x;

  logic [SUM_W-1:0]  total;
  logic [HITS_W-1:0] hits;
  logic [PIX_W-1:0]  peak;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_wdata, rdata;
  logic              rd_hit;

  assign raw_value = s_tdata[15:0];
  assign row       = s_tdata[22:16];
  assign column    = s_tdata[29:23];

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= '0;
      high_thr <= '1;
      mode     <= MODE_REORDER;
      win_sel  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW:  low_thr  <= cfg_data;
        REG_HIGH: high_thr <= cfg_data;
        REG_MODE: mode     <= mode_t'(cfg_data[1:0]);
        REG_WIN:  win_sel  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // lane k of readout position 4j+k lands at column j + k*stride
  assign load_col = CW'(column[POS_W-1:2]) + CW'(column[1:0]) * CW'(INTERLEAVE_STRIDE);
  assign in_raddr = AW'(AW'(row) * AW'(WIDTH)) + AW'(column);
  assign in_waddr = AW'(AW'(row) * AW'(WIDTH)) + AW'(load_col);

  assign half_y = win_sel ? (YW+1)'(2) : (YW+1)'(1);
  assign half_x = win_sel ? (XW+1)'(2) : (XW+1)'(1);
  assign cye    = {1'b0, cy};
  assign cxe    = {1'b0, cx};
  assign yhi    = cye + half_y;
  assign xhi    = cxe + half_x;
  assign y0_new = (cye >= half_y) ? YW'(cye - half_y) : '0;
  assign x0_new = (cxe >= half_x) ? XW'(cxe - half_x) : '0;
  assign y1_new = (yhi > (YW+1)'(HEIGHT - 1)) ? YW'(HEIGHT - 1) : yhi[YW-1:0];
  assign x1_new = (xhi > (XW+1)'(WIDTH - 1)) ? XW'(WIDTH - 1) : xhi[XW-1:0];

  assign rd_hit = rdata > low_thr;

  always_ff @(posedge clk) begin
    if (cmd.ctr_clear) begin
      cy <= '0;
      cx <= '0;
    end else if (cmd.ctr_next) begin
      if (cx == XW'(WIDTH - 1)) begin
        cx <= '0;
        cy <= cy + 1'b1;
      end else begin
        cx <= cx + 1'b1;
      end
    end

    if (cmd.win_start) begin
      y0 <= y0_new;
      y1 <= y1_new;
      x0 <= x0_new;
      x1 <= x1_new;
      wy <= y0_new;
      wx <= x0_new;
      py <= cy;
      px <= cx;
      total <= '0;
      hits  <= '0;
      peak  <= '0;
    end else begin
      if (cmd.win_rewind) begin
        wy <= y0;
        wx <= x0;
      end else if (cmd.win_next) begin
        if (wx == x1) begin
          wx <= x0;
          wy <= wy + 1'b1;
        end else begin
          wx <= wx + 1'b1;
        end
      end
      if (cmd.win_acc && rd_hit) begin
        total <= total + SUM_W'(rdata);
        hits  <= hits + 1'b1;
        if (rdata > peak) begin
          peak <= rdata;
          py   <= wy;
          px   <= wx;
        end
      end
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RS_CTR:  ram_raddr = AW'(AW'(cy) * AW'(WIDTH)) + AW'(cx);
      RS_WIN:  ram_raddr = AW'(AW'(wy) * AW'(WIDTH)) + AW'(wx);
      default: ram_raddr = in_raddr;
    endcase
  end

  always_comb begin
    ram_we = cmd.load_wr || cmd.clr_wr || cmd.put_wr;
    if (cmd.put_wr) begin
      ram_waddr = AW'(AW'(py) * AW'(WIDTH)) + AW'(px);
      ram_wdata = total[PIX_W-1:0];
    end else if (cmd.clr_wr) begin
      ram_waddr = AW'(AW'(wy) * AW'(WIDTH)) + AW'(wx);
      ram_wdata = '0;
    end else begin
      ram_waddr = in_waddr;
      ram_wdata = raw_value;
    end
  end

  ccl_ram #(
    .DATA_W(PIX_W),
    .DEPTH (WIDTH * HEIGHT)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_read || cmd.out_zero || cmd.out_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_read) begin
      m_tuser <= KIND_READ;
      m_tdata <= rdata;
    end else if (cmd.out_zero) begin
      m_tuser <= KIND_READ;
      m_tdata <= '0;
    end else if (cmd.out_done) begin
      m_tuser <= KIND_DONE;
      m_tdata <= '0;
    end
  end

  always_comb begin
    sts.op       = op_t'(s_tuser);
    sts.load_ok  = (CW'(row) < CW'(HEIGHT)) && (CW'(column) < CW'(4 * INTERLEAVE_STRIDE))
                   && (load_col < CW'(WIDTH));
    sts.read_ok  = (CW'(row) < CW'(HEIGHT)) && (CW'(column) < CW'(WIDTH));
    sts.run_on   = (mode == MODE_ADD) || (mode == MODE_DISCR);
    sts.add_mode = (mode == MODE_ADD);
    sts.ctr_hit  = rd_hit;
    sts.ctr_last = (cy == YW'(HEIGHT - 1)) && (cx == XW'(WIDTH - 1));
    sts.win_last = (wy == y1) && (wx == x1);
    sts.shared   = (hits > HITS_W'(1)) && (total < SUM_W'(high_thr));
    sts.out_busy = m_tvalid;
  end

  a_win_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.win_acc |-> (wy >= y0 && wy <= y1 && wx >= x0 && wx <= x1))
    else $error("window pointer left its bounds");

endmodule

// ----- tb/sv/charge_sharing_frame_cleanup_tb.sv -----
// Self-checking testbench for charge_sharing_frame_cleanup: directed table, frame fill, random phases.
module charge_sharing_frame_cleanup_tb;
  import ccl_pkg::*;

  localparam int NPIX      = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int WDOG_MAX  = 2000000;
  localparam int PHASE_LEN = 250;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } pix_word_t;

  typedef struct {
    op_t         op;
    logic [15:0] raw;
    logic [6:0]  row;
    logic [6:0]  col;
    bit          typed;
    logic        kind;
    logic [15:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LOW;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  logic [15:0] pix_mem [NPIX];
  logic [15:0] low_thr;
  logic [15:0] high_thr;
  logic [1:0]  mode_reg;
  logic        win_reg;

  pix_word_t   expected_q[$];
  int          tx_idle = 0;
  int          rx_idle = 0;
  bit          hold_req = 0;
  int          hold_cnt = 0;
  int          err_cnt = 0;
  int          quiet_cycles = 0;

  charge_sharing_frame_cleanup uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // clean one window in place, as the block does during a run
  function automatic void scrub_window(int cy, int cx, int half, bit add);
    int y0, x0, y1, x1, py, px;
    logic [31:0] total;
    int hits;
    logic [15:0] peak, v;
    y0 = (cy - half < 0) ? 0 : cy - half;
    x0 = (cx - half < 0) ? 0 : cx - half;
    y1 = (cy + half > FRAME_HEIGHT - 1) ? FRAME_HEIGHT - 1 : cy + half;
    x1 = (cx + half > FRAME_WIDTH - 1) ? FRAME_WIDTH - 1 : cx + half;
    total = 0; hits = 0; peak = 0; py = cy; px = cx;
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++) begin
        v = pix_mem[y * FRAME_WIDTH + x];
        if (v > low_thr) begin
          total += v;
          hits++;
          if (v > peak) begin
            peak = v; py = y; px = x;
          end
        end
      end
    if (hits > 1 && total < {16'd0, high_thr}) begin
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          pix_mem[y * FRAME_WIDTH + x] = '0;
      if (add) pix_mem[py * FRAME_WIDTH + px] = total[15:0];
    end
  endfunction

  function automatic void frame_step(op_t op, logic [15:0] raw, logic [6:0] r, logic [6:0] c,
                                     output bit has, output pix_word_t res);
    int col;
    has = 0;
    res = '0;
    case (op)
      OP_LOAD: begin
        col = c / 4 + (c % 4) * STRIDE;
        if (r < FRAME_HEIGHT && c < 4 * STRIDE && col < FRAME_WIDTH)
          pix_mem[r * FRAME_WIDTH + col] = raw;
      end
      OP_RUN: begin
        if (mode_reg == MODE_ADD || mode_reg == MODE_DISCR)
          for (int y = 0; y < FRAME_HEIGHT; y++)
            for (int x = 0; x < FRAME_WIDTH; x++)
              if (pix_mem[y * FRAME_WIDTH + x] > low_thr)
                scrub_window(y, x, win_reg ? 2 : 1, mode_reg == MODE_ADD);
        has = 1;
        res = '{KIND_DONE, 16'd0};
      end
      OP_READ: begin
        has = 1;
        res.kind = KIND_READ;
        if (r < FRAME_HEIGHT && c < FRAME_WIDTH) res.value = pix_mem[r * FRAME_WIDTH + c];
      end
      default: ;
    endcase
  endfunction

  task automatic push_word(op_t op, logic [15:0] raw, logic [6:0] r, logic [6:0] c,
                           bit typed = 0, pix_word_t typed_res = '0);
    bit has;
    pix_word_t res;
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {2'b00, c, r, raw};
    do @(posedge clk); while (!s_tready);
    frame_step(op, raw, r, c, has, res);
    if (typed) expected_q = {expected_q, typed_res};
    else if (has) expected_q = {expected_q, res};
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    while (expected_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_LOW:  low_thr  = val;
      REG_HIGH: high_thr = val;
      REG_MODE: mode_reg = val[1:0];
      default:  win_reg  = val[0];
    endcase
  endtask

  // sparse hits keep run time down
  function automatic logic [15:0] pick_pixel();
    int p;
    p = $urandom_range(99);
    if (p < 90) return 16'd0;
    if (p < 96) return 16'($urandom_range(300, 1));
    return 16'($urandom_range(65535));
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: kind %0d value %h", m_tuser, m_tdata);
        err_cnt++;
      end else begin
        pix_word_t e;
        e = expected_q.pop_front();
        if (m_tuser !== e.kind) begin
          $error("result_kind: expected %0d, got %0d", e.kind, m_tuser);
          err_cnt++;
        end
        if (m_tdata !== e.value) begin
          $error("pixel_value: expected %h, got %h", e.value, m_tdata);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_tab[16];
    logic [15:0] phase_cfg[7][4];
    int p, n, op_sel;
    logic [6:0] r, c;

    dir_tab = '{
      '{OP_LOAD, 16'hFFFF, 7'd0,   7'd0,   0, 1'b0, 16'h0},
      '{OP_READ, 16'h0,    7'd0,   7'd0,   1, KIND_READ, 16'hFFFF},
      '{OP_LOAD, 16'h1234, 7'd0,   7'd1,   0, 1'b0, 16'h0},
      '{OP_READ, 16'h0,    7'd0,   7'd20,  1, KIND_READ, 16'h1234},
      '{OP_LOAD, 16'hAAAA, 7'd79,  7'd79,  0, 1'b0, 16'h0},
      '{OP_READ, 16'h0,    7'd79,  7'd79,  1, KIND_READ, 16'hAAAA},
      '{OP_LOAD, 16'h5555, 7'd0,   7'd6,   0, 1'b0, 16'h0},
      '{OP_READ, 16'h0,    7'd0,   7'd41,  1, KIND_READ, 16'h5555},
      '{OP_LOAD, 16'h0000, 7'd80,  7'd0,   0, 1'b0, 16'h0},
      '{OP_LOAD, 16'h0000, 7'd0,   7'd80,  0, 1'b0, 16'h0},
      '{OP_LOAD, 16'h0000, 7'd127, 7'd127, 0, 1'b0, 16'h0},
      '{OP_NONE, 16'hFFFF, 7'd0,   7'd0,   0, 1'b0, 16'h0},
      '{OP_READ, 16'h0,    7'd0,   7'd0,   1, KIND_READ, 16'hFFFF},
      '{OP_READ, 16'h0,    7'd127, 7'd0,   1, KIND_READ, 16'h0},
      '{OP_READ, 16'h0,    7'd0,   7'd127, 1, KIND_READ, 16'h0},
      '{OP_READ, 16'h0,    7'd80,  7'd80,  1, KIND_READ, 16'h0}
    };
    phase_cfg = '{
      '{16'd0,     16'd65535, MODE_ADD,     16'd0},
      '{16'd65535, 16'd0,     MODE_DISCR,   16'd1},
      '{16'd20,    16'd3000,  MODE_ADD,     16'd1},
      '{16'd5,     16'd1000,  MODE_DISCR,   16'd0},
      '{16'd0,     16'd65535, MODE_SPARE,   16'd1},
      '{16'd100,   16'd20000, MODE_REORDER, 16'd0},
      '{16'd0,     16'd40000, MODE_ADD,     16'd0}
    };
    low_thr = 16'd0; high_thr = 16'hFFFF; mode_reg = MODE_REORDER; win_reg = 1'b0;
    for (int i = 0; i < NPIX; i++) pix_mem[i] = '0;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i])
      push_word(dir_tab[i].op, dir_tab[i].raw, dir_tab[i].row, dir_tab[i].col,
                dir_tab[i].typed, '{dir_tab[i].kind, dir_tab[i].value});

    // every pixel written before the first run
    for (int y = 0; y < FRAME_HEIGHT; y++)
      for (int x = 0; x < 4 * STRIDE; x++)
        push_word(OP_LOAD, pick_pixel(), 7'(y), 7'(x));
    push_word(OP_RUN, 16'h0, 7'd0, 7'd0, 1, '{KIND_DONE, 16'h0});

    for (p = 0; p < 7; p++) begin
      write_reg(REG_LOW,  phase_cfg[p][0]);
      write_reg(REG_HIGH, phase_cfg[p][1]);
      write_reg(REG_MODE, phase_cfg[p][2]);
      write_reg(REG_WIN,  phase_cfg[p][3]);
      tx_idle = (p < 2) ? 14 : (p < 4) ? 49 : 0;
      rx_idle = (p < 2) ? 49 : (p < 4) ? 14 : 0;
      push_word(OP_RUN, 16'h0, 7'd0, 7'd0);
      for (n = 0; n < PHASE_LEN; n++) begin
        if (p == 0 && n == 100) hold_req = 1;
        op_sel = $urandom_range(999);
        r = ($urandom_range(99) < 85) ? 7'($urandom_range(79)) : 7'($urandom_range(127));
        c = ($urandom_range(99) < 85) ? 7'($urandom_range(79)) : 7'($urandom_range(127));
        if (op_sel < 4)        push_word(OP_RUN, 16'($urandom_range(65535)), r, c);
        else if (op_sel < 20)  push_word(OP_NONE, 16'($urandom_range(65535)), r, c);
        else if (op_sel < 500) push_word(OP_LOAD, pick_pixel(), r, c);
        else                   push_word(OP_READ, 16'($urandom_range(65535)), r, c);
      end
    end

    while (expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/ccl_pkg.sv
design/ccl_ram.sv
design/ccl_ctrl.sv
design/ccl_dp.sv
design/charge_sharing_frame_cleanup.sv
tb/sv/charge_sharing_frame_cleanup_tb.sv
